// ----- hdl/drm_pkg.sv -----
// shared constants, opcode codes and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none

package drm_pkg;

  localparam int MEM_WORDS = 1000;
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int WORD_W    = 10;
  localparam int NUM_REGS  = 10;
  localparam int RIDX_W    = $clog2(NUM_REGS);
  localparam int STEP_W    = 24;
  localparam int PROD_W    = 2 * WORD_W;

  localparam logic [WORD_W-1:0] WORD_MOD    = WORD_W'(1000);
  localparam logic [STEP_W-1:0] LIMIT_RESET = {STEP_W{1'b1}};
  // ceil(2^30 / 1000): exact floor(x / 1000) for every x below 2^20
  localparam int RECIP_SHIFT = 30;
  localparam logic [20:0] RECIP_1000 = 21'd1073742;

  typedef enum logic [3:0] {
    OP_JUMP  = 4'd0,
    OP_HALT  = 4'd1,
    OP_SET   = 4'd2,
    OP_ADDI  = 4'd3,
    OP_MULI  = 4'd4,
    OP_COPY  = 4'd5,
    OP_ADDR  = 4'd6,
    OP_MULR  = 4'd7,
    OP_LOAD  = 4'd8,
    OP_STORE = 4'd9
  } op_e;

  // commands from the controller, at most one step command per cycle
  typedef struct packed {
    logic load;      // store an input word at the load pointer
    logic run_init;  // start a run at address zero
    logic fetch;     // read the instruction at the program counter
    logic decode;    // split the instruction word into digits
    logic reg_read;  // read both registers and count the step
    logic exec;      // execute, or start the arithmetic path
    logic quot;      // quotient by 1000
    logic modw;      // remainder write back
    logic ld_wb;     // memory load write back
    logic clr;       // one step of the clearing pass
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic limit_hit;
    logic clr_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/drm_ctrl.sv -----
// controller state machine of the decimal register machine
`timescale 1ns / 1ps
`default_nettype none

module drm_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             func_i,
  input  wire drm_pkg::dp_stat_t stat_i,
  output drm_pkg::dp_cmd_t      cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import drm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_FETCH = 10'b0000000010,
    S_DEC   = 10'b0000000100,
    S_REGRD = 10'b0000001000,
    S_EXEC  = 10'b0000010000,
    S_QUOT  = 10'b0000100000,
    S_MODW  = 10'b0001000000,
    S_LDWB  = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_CLEAR = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  state_e after_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state once an instruction has finished
  assign after_d = stat_i.limit_hit ? S_DONE : S_FETCH;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_i) begin
            cmd_o.run_init = 1'b1;
            state_d        = S_FETCH;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = S_DEC;
      end
      S_DEC: begin
        cmd_o.decode = 1'b1;
        state_d      = S_REGRD;
      end
      S_REGRD: begin
        cmd_o.reg_read = 1'b1;
        state_d        = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        case (stat_i.op)
          OP_HALT: state_d = S_DONE;
          OP_ADDI, OP_MULI, OP_ADDR, OP_MULR: state_d = S_QUOT;
          OP_LOAD: state_d = S_LDWB;
          default: state_d = after_d;
        endcase
      end
      S_QUOT: begin
        cmd_o.quot = 1'b1;
        state_d    = S_MODW;
      end
      S_MODW: begin
        cmd_o.modw = 1'b1;
        state_d    = after_d;
      end
      S_LDWB: begin
        cmd_o.ld_wb = 1'b1;
        state_d     = after_d;
      end
      S_DONE: begin
        state_d = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

`default_nettype wire

// ----- hdl/drm_dp.sv -----
// datapath: program memory, register file, decoder, arithmetic and counters
`timescale 1ns / 1ps
`default_nettype none

module drm_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire drm_pkg::dp_cmd_t            cmd_i,
  input  wire logic [drm_pkg::WORD_W-1:0]  word_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [drm_pkg::STEP_W-1:0]  cfg_wdata_i,
  output drm_pkg::dp_stat_t                stat_o,
  output logic [drm_pkg::STEP_W-1:0]       steps_o,
  output logic                             status_o
);
  import drm_pkg::*;

  // storage
  logic [WORD_W-1:0] mem_q [MEM_WORDS];
  logic [WORD_W-1:0] rf_q  [NUM_REGS];
  logic [WORD_W-1:0] mem_rdata_q;

  // control registers
  logic [STEP_W-1:0] limit_q;
  logic [STEP_W-1:0] cnt_q;
  logic [ADDR_W-1:0] pc_q;
  logic [ADDR_W-1:0] lp_q;
  logic [ADDR_W-1:0] clr_q;
  op_e               op_q;

  // decode and operand registers
  logic [WORD_W-1:0] inst_q;
  logic [3:0]        q100_q;
  logic [6:0]        q10_q;
  logic [RIDX_W-1:0] d_q;
  logic [RIDX_W-1:0] s_q;
  logic [WORD_W-1:0] rd_d_q;
  logic [WORD_W-1:0] rd_s_q;
  logic [PROD_W-1:0] prod_q;
  logic [WORD_W-1:0] quo_q;

  // combinational
  logic [15:0]       m100;
  logic [17:0]       m10;
  logic [6:0]        d_full;
  logic [WORD_W-1:0] s_full;
  logic [RIDX_W-1:0] d_idx;
  logic [RIDX_W-1:0] s_idx;
  logic              is_mul;
  logic [WORD_W-1:0] arith_b;
  logic [PROD_W-1:0] prod_d;
  logic [40:0]       quo_full;
  logic [PROD_W-1:0] quo_x1000;
  logic [PROD_W-1:0] rem_full;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] word_red;
  logic [STEP_W-1:0] limit_eff;
  logic              jump_taken;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic              rf_we;
  logic [RIDX_W-1:0] rf_waddr;
  logic [WORD_W-1:0] rf_wdata;

  // digit split by reciprocal multiply, exact for words below 1000
  assign m100   = {6'd0, mem_rdata_q} * 16'd41;
  assign m10    = {8'd0, mem_rdata_q} * 18'd205;
  assign d_full = q10_q - ({3'd0, q100_q} << 3) - ({3'd0, q100_q} << 1);
  assign s_full = inst_q - ({3'd0, q10_q} << 3) - ({3'd0, q10_q} << 1);
  assign d_idx  = d_full[RIDX_W-1:0];
  assign s_idx  = s_full[RIDX_W-1:0];

  // arithmetic path: sum or product, then quotient, then remainder
  assign is_mul  = (op_q == OP_MULI) || (op_q == OP_MULR);
  assign arith_b = ((op_q == OP_ADDI) || (op_q == OP_MULI)) ?
                   {{(WORD_W-RIDX_W){1'b0}}, s_q} : rd_s_q;
  assign prod_d  = is_mul ? ({{WORD_W{1'b0}}, rd_d_q} * {{WORD_W{1'b0}}, arith_b})
                          : ({{WORD_W{1'b0}}, rd_d_q} + {{WORD_W{1'b0}}, arith_b});
  assign quo_full  = {21'd0, prod_q} * {20'd0, RECIP_1000};
  assign quo_x1000 = ({{WORD_W{1'b0}}, quo_q} << 10) - ({{WORD_W{1'b0}}, quo_q} << 4)
                   - ({{WORD_W{1'b0}}, quo_q} << 3);
  assign rem_full  = prod_q - quo_x1000;
  assign rem       = (rem_full[WORD_W-1:0] >= WORD_MOD) ? rem_full[WORD_W-1:0] - WORD_MOD
                                                        : rem_full[WORD_W-1:0];

  assign word_red   = (word_i >= WORD_MOD) ? word_i - WORD_MOD : word_i;
  assign limit_eff  = (limit_q == '0) ? STEP_W'(1) : limit_q;
  assign jump_taken = (op_q == OP_JUMP) && (rd_s_q != '0);

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = lp_q;
    mem_wdata = word_red;
    if (cmd_i.load) begin
      mem_we = (lp_q < ADDR_W'(MEM_WORDS));
    end else if (cmd_i.exec && (op_q == OP_STORE)) begin
      mem_we    = 1'b1;
      mem_waddr = rd_s_q;
      mem_wdata = rd_d_q;
    end else if (cmd_i.clr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end
  end

  assign mem_raddr = cmd_i.exec ? rd_s_q : pc_q;

  // instruction read on fetch, operand read on execute
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.fetch || cmd_i.exec) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // register file write selection
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = d_q;
    rf_wdata = rem;
    if (cmd_i.clr) begin
      rf_we    = (clr_q < ADDR_W'(NUM_REGS));
      rf_waddr = clr_q[RIDX_W-1:0];
      rf_wdata = '0;
    end else if (cmd_i.exec && (op_q == OP_SET)) begin
      rf_we    = 1'b1;
      rf_wdata = {{(WORD_W-RIDX_W){1'b0}}, s_q};
    end else if (cmd_i.exec && (op_q == OP_COPY)) begin
      rf_we    = 1'b1;
      rf_wdata = rd_s_q;
    end else if (cmd_i.modw) begin
      rf_we = 1'b1;
    end else if (cmd_i.ld_wb) begin
      rf_we    = 1'b1;
      rf_wdata = mem_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_waddr] <= rf_wdata;
    end
    if (cmd_i.reg_read) begin
      rd_d_q <= rf_q[d_idx];
      rd_s_q <= rf_q[s_idx];
    end
  end

  // payload pipeline registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode) begin
      inst_q <= mem_rdata_q;
      q100_q <= m100[15:12];
      q10_q  <= m10[17:11];
    end
    if (cmd_i.reg_read) begin
      d_q <= d_idx;
      s_q <= s_idx;
    end
    if (cmd_i.exec) begin
      prod_q <= prod_d;
    end
    if (cmd_i.quot) begin
      quo_q <= quo_full[RECIP_SHIFT+WORD_W-1:RECIP_SHIFT];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      cnt_q   <= '0;
      pc_q    <= '0;
      lp_q    <= '0;
      clr_q   <= '0;
      op_q    <= OP_JUMP;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load && (lp_q < ADDR_W'(MEM_WORDS))) begin
        lp_q <= lp_q + ADDR_W'(1);
      end
      if (cmd_i.run_init) begin
        pc_q  <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.reg_read) begin
        op_q  <= op_e'(q100_q);
        cnt_q <= cnt_q + STEP_W'(1);
      end
      if (cmd_i.exec) begin
        if (jump_taken) begin
          pc_q <= rd_d_q;
        end else if (pc_q == ADDR_W'(MEM_WORDS - 1)) begin
          pc_q <= '0;
        end else begin
          pc_q <= pc_q + ADDR_W'(1);
        end
      end
      if (cmd_i.clr) begin
        cnt_q <= '0;
        pc_q  <= '0;
        lp_q  <= '0;
        clr_q <= stat_o.clr_last ? '0 : clr_q + ADDR_W'(1);
      end
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.limit_hit = (cnt_q >= limit_eff);
  assign stat_o.clr_last  = (clr_q == ADDR_W'(MEM_WORDS - 1));

  assign steps_o  = cnt_q;
  assign status_o = (op_q != OP_HALT);

endmodule

`default_nettype wire

// ----- hdl/decimal_register_machine_top.sv -----
// top level of the decimal register machine: controller plus datapath
`timescale 1ns / 1ps
`default_nettype none

// decimal register machine with ten registers and a 1000-word program memory.
// a transfer is taken at a rising edge with start high and busy low. func_i = 0
// stores word_i (reduced modulo 1000) at the next load address and leaves busy
// low, so loads may follow every cycle; loads past 1000 words are dropped.
// func_i = 1 runs the program from address 0. each instruction passes through
// fetch, decode, register read and execute; the add and multiply forms then go
// through the shared quotient-by-1000 path (quotient, remainder write back) and
// a memory load through a second memory port step (load write back). the result
// (steps_o, status_o) is shown for exactly one cycle with done_o high; the
// receiver cannot stall it, so it must take it then. after every result, and
// after reset, a clearing pass zeroes memory and registers with busy high;
// config writes (cfg_we_i) are taken at any time but belong in idle periods. a
// step limit of zero acts as one.
module decimal_register_machine_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       func_i,
  input  wire logic [drm_pkg::WORD_W-1:0] word_i,
  input  wire logic                       cfg_we_i,
  input  wire logic [drm_pkg::STEP_W-1:0] cfg_wdata_i,
  output logic                            done_o,
  output logic [drm_pkg::STEP_W-1:0]      steps_o,
  output logic                            status_o
);
  import drm_pkg::*;

  // command and status between the state machine and the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  drm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  drm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .word_i      (word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .stat_o      (stat),
    .steps_o     (steps_o),
    .status_o    (status_o)
  );

  // a run transfer makes the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i) |=> busy)
    else $error("run transfer did not start the machine");

  // a load transfer is finished in its own cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !func_i) |=> !busy)
    else $error("load transfer left the machine busy");

  // the clearing pass follows every result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (busy && !done_o))
    else $error("result not followed by clearing pass");

  // a result never appears while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (busy && (steps_o != '0)))
    else $error("result strobe with idle machine or zero step count");

endmodule

`default_nettype wire

// ----- tb/sv/tb_decimal_register_machine_top.sv -----
// self-checking testbench for the decimal register machine: run predictor, checker and stimulus
`timescale 1ns / 1ps

typedef enum logic {
  FUNC_LOAD = 1'b0,
  FUNC_RUN  = 1'b1
} func_e;

typedef enum logic {
  ST_HALTED = 1'b0,
  ST_LIMIT  = 1'b1
} run_status_e;

class program_run_tracker;
  localparam int WORD_MOD = 1000;

  typedef struct {
    logic [drm_pkg::STEP_W-1:0] steps;
    logic                       status;
  } outcome_t;

  logic [drm_pkg::WORD_W-1:0] prog_mem [drm_pkg::MEM_WORDS];
  logic [drm_pkg::WORD_W-1:0] regs [drm_pkg::NUM_REGS];
  int unsigned                load_ptr;
  logic [drm_pkg::STEP_W-1:0] step_limit;
  outcome_t                   due_outcomes [$];
  int unsigned                errors;
  int unsigned                loads;
  int unsigned                runs;
  int unsigned                limit_runs;

  function new();
    step_limit = drm_pkg::LIMIT_RESET;
    errors = 0;
    loads = 0;
    runs = 0;
    limit_runs = 0;
    clear_machine();
  endfunction

  function void clear_machine();
    foreach (prog_mem[i]) prog_mem[i] = '0;
    foreach (regs[i]) regs[i] = '0;
    load_ptr = 0;
  endfunction

  function void set_limit(logic [drm_pkg::STEP_W-1:0] v);
    step_limit = v;
  endfunction

  function int unsigned outstanding();
    return due_outcomes.size();
  endfunction

  // executes the loaded program from address zero until a halt or the step limit
  function outcome_t run_to_halt_or_limit();
    outcome_t     res;
    int unsigned  lim, pc, next_pc, inst, d, s, a, b, count;
    drm_pkg::op_e op;
    logic         halted;
    lim = (step_limit == 0) ? 1 : step_limit;
    pc = 0;
    count = 0;
    halted = 1'b0;
    while (!halted && count < lim) begin
      inst = prog_mem[pc];
      op = drm_pkg::op_e'(4'(inst / 100));
      d = (inst / 10) % 10;
      s = inst % 10;
      a = regs[d];
      b = regs[s];
      next_pc = (pc + 1 == drm_pkg::MEM_WORDS) ? 0 : pc + 1;
      count++;
      case (op)
        drm_pkg::OP_HALT:  halted = 1'b1;
        drm_pkg::OP_SET:   regs[d] = drm_pkg::WORD_W'(s);
        drm_pkg::OP_ADDI:  regs[d] = drm_pkg::WORD_W'((a + s) % WORD_MOD);
        drm_pkg::OP_MULI:  regs[d] = drm_pkg::WORD_W'((a * s) % WORD_MOD);
        drm_pkg::OP_COPY:  regs[d] = drm_pkg::WORD_W'(b);
        drm_pkg::OP_ADDR:  regs[d] = drm_pkg::WORD_W'((a + b) % WORD_MOD);
        drm_pkg::OP_MULR:  regs[d] = drm_pkg::WORD_W'((a * b) % WORD_MOD);
        drm_pkg::OP_LOAD:  regs[d] = prog_mem[b];
        drm_pkg::OP_STORE: prog_mem[b] = drm_pkg::WORD_W'(a);
        drm_pkg::OP_JUMP: begin
          if (b != 0) next_pc = a % drm_pkg::MEM_WORDS;
        end
        default: ;
      endcase
      pc = next_pc;
    end
    res.steps = drm_pkg::STEP_W'(count);
    res.status = halted ? ST_HALTED : ST_LIMIT;
    return res;
  endfunction

  // called once per accepted transfer
  function void note_transfer(func_e f, logic [drm_pkg::WORD_W-1:0] w);
    outcome_t res;
    if (f == FUNC_LOAD) begin
      if (load_ptr < drm_pkg::MEM_WORDS) begin
        prog_mem[load_ptr] = drm_pkg::WORD_W'(int'(w) % WORD_MOD);
        load_ptr++;
        loads++;
      end
    end else begin
      res = run_to_halt_or_limit();
      if (res.status == ST_LIMIT) limit_runs++;
      due_outcomes.push_back(res);
      clear_machine();
    end
  endfunction

  function void check_result(logic [drm_pkg::STEP_W-1:0] got_steps, logic got_status);
    outcome_t want;
    if (due_outcomes.size() == 0) begin
      $error("result with no run outstanding: steps %0d status %0d", got_steps, got_status);
      errors++;
      return;
    end
    want = due_outcomes.pop_front();
    runs++;
    if (got_steps !== want.steps) begin
      $error("steps mismatch: expected %0d, got %0d", want.steps, got_steps);
      errors++;
    end
    if (got_status !== want.status) begin
      $error("status mismatch: expected %0d, got %0d", want.status, got_status);
      errors++;
    end
  endfunction
endclass

module tb_decimal_register_machine_top;
  import drm_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 10;
  localparam int ITEM_TARGET   = 1450;
  // even with every transfer a run at the largest limit used, plus its clearing pass,
  // the run stays several times under this limit
  localparam int CYCLE_LIMIT   = 60_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int WRAP_LIMIT    = 1200;
  localparam int FULL_LIMIT    = 1500;
  localparam int WORD_MAX      = 2 ** WORD_W - 1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              func = FUNC_LOAD;
  logic [WORD_W-1:0] word = '0;
  logic              cfg_we = 1'b0;
  logic [STEP_W-1:0] cfg_wdata = '0;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic              status;

  program_run_tracker tracker;
  int unsigned        items_sent = 0;
  logic               gaps_on = 1'b1;
  logic [STEP_W-1:0]  min_limit = '1;
  logic [STEP_W-1:0]  max_limit = '0;

  decimal_register_machine_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start       (start),
    .busy        (busy),
    .func_i      (func),
    .word_i      (word),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .done_o      (done),
    .steps_o     (steps),
    .status_o    (status)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // results cannot be held off, so every strobe is taken on the cycle it shows
  always @(posedge clk) begin
    if (rst_n && done) tracker.check_result(steps, status);
  end

  // assemble an instruction word from its three decimal digits
  function automatic logic [WORD_W-1:0] instr(op_e op, int unsigned d, int unsigned s);
    return WORD_W'(int'(op) * 100 + d * 10 + s);
  endfunction

  // ordinary program body: no halt, jumps kept rare so most programs reach the end
  function automatic logic [WORD_W-1:0] body_word();
    op_e op;
    if ($urandom_range(9) == 0) op = OP_JUMP;
    else op = op_e'(4'($urandom_range(OP_STORE, OP_SET)));
    return instr(op, $urandom_range(9), $urandom_range(9));
  endfunction

  function automatic logic [STEP_W-1:0] pick_limit();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) return '0;
    if (sel < 25) return STEP_W'($urandom_range(8, 1));
    if (sel < 85) return STEP_W'($urandom_range(300, 9));
    return STEP_W'($urandom_range(FULL_LIMIT, 301));
  endfunction

  // one transfer: an occasional gap, then start held high until busy is low at an edge;
  // start stays high on return so back-to-back loads go out every cycle unless a gap is drawn
  task automatic send_item(func_e f, logic [WORD_W-1:0] w);
    if (gaps_on && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    start <= 1'b1;
    func  <= f;
    word  <= w;
    do @(posedge clk); while (busy);
    tracker.note_transfer(f, w);
    items_sent++;
  endtask

  // stop sending, let every run report, then wait out the clearing pass
  task automatic wait_idle();
    start <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_limit(logic [STEP_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    tracker.set_limit(v);
    cfg_we <= 1'b0;
    if (v < min_limit) min_limit = v;
    if (v > max_limit) max_limit = v;
  endtask

  // mostly well-formed programs, most of them ending in a halt, some raw noise, some empty memory
  task automatic send_random_program();
    int unsigned kind, n;
    kind = $urandom_range(99);
    n = $urandom_range(12, 1);
    if (kind < 80) begin
      repeat (n) send_item(FUNC_LOAD, body_word());
      if ($urandom_range(3) != 0)
        send_item(FUNC_LOAD, instr(OP_HALT, $urandom_range(9), $urandom_range(9)));
    end else if (kind < 92) begin
      repeat (n) send_item(FUNC_LOAD, WORD_W'($urandom_range(WORD_MAX)));
    end
    send_item(FUNC_RUN, WORD_W'($urandom_range(WORD_MAX)));
    // now and then the sender holds back until the result is in
    if ($urandom_range(9) == 0) wait_idle();
  endtask

  // fills every address with straight-line code, then offers halts past the end;
  // those must be dropped, so the run wraps the program counter and hits the limit
  task automatic send_full_memory();
    gaps_on = 1'b0;
    repeat (MEM_WORDS)
      send_item(FUNC_LOAD, instr(op_e'(4'($urandom_range(OP_LOAD, OP_SET))),
                                 $urandom_range(9), $urandom_range(9)));
    repeat (3) send_item(FUNC_LOAD, instr(OP_HALT, 0, 0));
    send_item(FUNC_RUN, '0);
    gaps_on = 1'b1;
  endtask

  initial begin
    int unsigned phase;
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: zero word, words at and above the top of the field, then a halt
    send_item(FUNC_LOAD, '0);
    send_item(FUNC_LOAD, WORD_W'(WORD_MAX));
    send_item(FUNC_LOAD, WORD_W'(1000));
    send_item(FUNC_LOAD, WORD_W'(999));
    send_item(FUNC_LOAD, instr(OP_HALT, 0, 0));
    send_item(FUNC_RUN, '0);

    // every opcode at least once, with a taken jump skipping one word
    write_limit(LIMIT_RESET);
    send_item(FUNC_LOAD, instr(OP_SET, 1, 5));
    send_item(FUNC_LOAD, instr(OP_ADDI, 2, 7));
    send_item(FUNC_LOAD, instr(OP_MULI, 1, 7));
    send_item(FUNC_LOAD, instr(OP_COPY, 5, 2));
    send_item(FUNC_LOAD, instr(OP_ADDR, 1, 5));
    send_item(FUNC_LOAD, instr(OP_MULR, 1, 1));
    send_item(FUNC_LOAD, instr(OP_STORE, 2, 1));
    send_item(FUNC_LOAD, instr(OP_LOAD, 4, 1));
    send_item(FUNC_LOAD, instr(OP_SET, 7, 9));
    send_item(FUNC_LOAD, instr(OP_ADDI, 7, 3));
    send_item(FUNC_LOAD, instr(OP_JUMP, 7, 5));
    send_item(FUNC_LOAD, instr(OP_SET, 9, 9));
    send_item(FUNC_LOAD, instr(OP_HALT, 0, 0));
    send_item(FUNC_RUN, WORD_W'(WORD_MAX));

    // zero limit acts as one, and a halt on that single step is still a normal halt
    write_limit('0);
    send_item(FUNC_LOAD, instr(OP_HALT, 0, 0));
    send_item(FUNC_RUN, '0);

    // limit of one on empty memory stops with limit status
    write_limit(STEP_W'(1));
    send_item(FUNC_RUN, '0);

    // empty memory never halts: the program counter wraps from 999 to 0
    write_limit(STEP_W'(WRAP_LIMIT));
    send_item(FUNC_RUN, '0);

    // random phases, each under its own step limit
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase == 3) begin
        write_limit(STEP_W'(FULL_LIMIT));
        send_full_memory();
      end
      write_limit(pick_limit());
      repeat ($urandom_range(8, 3)) send_random_program();
      phase++;
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d program word loads and %0d runs, %0d stopped by the step limit",
             tracker.loads, tracker.runs, tracker.limit_runs);
    $display("step limits from %0d to %0d, one program filling all of memory",
             min_limit, max_limit);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- decimal_register_machine_top.f -----
hdl/drm_pkg.sv
hdl/drm_ctrl.sv
hdl/drm_dp.sv
hdl/decimal_register_machine_top.sv
tb/sv/tb_decimal_register_machine_top.sv
